FILE: sv/pfrs_pkg.sv
// Package for the per-flow receive sequence and delay statistics block.
// Holds the flow-table geometry, the item kind codes and the queue and result types.
// No dependencies.
package pfrs_pkg;

	localparam int NUM_SOURCES = 16;
	localparam int NUM_DESTS   = 16;
	localparam int NUM_FLOWS   = NUM_SOURCES * NUM_DESTS;
	localparam int FLOW_W      = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;

	localparam logic [15:0] TEST_MARKER = 16'hFFFF;

	// Depth of the queue between the front and back parts.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_FWD,
		KIND_STAT
	} item_kind_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		item_kind_t        kind;
		logic [FLOW_W-1:0] flow;
		logic [15:0]       pkt_size;
		logic [31:0]       seq_number;
		logic [31:0]       delay;
	} item_t;

	// One entry of the flow table.
	typedef struct packed {
		logic [31:0] last_seq;
		logic [31:0] loss;
		logic [31:0] pkts;
		logic [31:0] bytes;
		logic [31:0] dmax;
		logic [31:0] dmin;
	} flow_t;

	typedef struct packed {
		logic        forward_up;
		logic        stats_updated;
		logic [31:0] flow_pkt_count;
		logic [31:0] flow_byte_count;
		logic [31:0] flow_loss_count;
		logic [31:0] one_way_delay;
		logic [31:0] delay_min;
		logic [31:0] delay_max;
	} result_t;

endpackage

FILE: sv/pfrs_front.sv
// Front part: takes a packet header, classifies it and forms the queue item.
// Depends on pfrs_pkg.
module pfrs_front (
	input  logic                  start,
	input  logic                  q_full,
	output logic                  busy,
	output logic                  push,
	input  logic                  packet_present,
	input  logic [3:0]            src_index,
	input  logic [3:0]            dst_index,
	input  logic signed [31:0]    now_time,
	input  logic [15:0]           marker,
	input  logic [15:0]           pkt_size,
	input  logic [31:0]           seq_number,
	input  logic signed [31:0]    send_time,
	output pfrs_pkg::item_t       item
);
	import pfrs_pkg::*;

	logic in_range;
	logic [31:0] flow_full;

	assign busy = q_full;
	assign push = start && !q_full;

	assign in_range  = (32'(src_index) < NUM_SOURCES) && (32'(dst_index) < NUM_DESTS);
	assign flow_full = 32'(src_index) * NUM_DESTS + 32'(dst_index);

	always_comb begin
		item.flow       = flow_full[FLOW_W-1:0];
		item.pkt_size   = pkt_size;
		item.seq_number = seq_number;
		item.delay      = now_time - send_time;
		if (!packet_present) begin
			item.kind = KIND_NONE;
		end else if (marker != TEST_MARKER) begin
			item.kind = KIND_FWD;
		end else if (!in_range) begin
			item.kind = KIND_NONE;
		end else begin
			item.kind = KIND_STAT;
		end
	end

endmodule

FILE: sv/pfrs_fifo.sv
// Short queue of classified items between the front and back parts.
// Depends on pfrs_pkg.
module pfrs_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pfrs_pkg::item_t push_item,
	input  logic            pop,
	output pfrs_pkg::item_t head,
	output logic            empty,
	output logic            full
);
	import pfrs_pkg::*;

	item_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		logic [Q_PTR_W-1:0] r;
		if (p == Q_PTR_W'(Q_DEPTH - 1)) r = '0;
		else r = p + 1'b1;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: sv/pfrs_back.sv
// Back part: reads the flow table, updates it and registers the result.
// Depends on pfrs_pkg; holds the flow table memory and its valid bits.
module pfrs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pfrs_pkg::item_t   head,
	input  logic              empty,
	output logic              pop,
	output logic              done,
	output pfrs_pkg::result_t res
);
	import pfrs_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t   state_q;
	logic     done_q;
	result_t  res_q;
	logic     vld_q [NUM_FLOWS];
	logic     vld_s1;
	item_t    cur_s1;
	flow_t    rd_s1;
	flow_t    mem [NUM_FLOWS];

	flow_t    old_f;
	flow_t    new_f;
	logic [31:0] expected;
	logic     is_stat;
	result_t  fwd_res;

	assign is_stat = (head.kind == KIND_STAT);
	assign pop     = (state_q == ST_IDLE) && !empty;
	assign done    = done_q;
	assign res     = res_q;

	// An entry never written since reset reads as all zero.
	assign old_f    = vld_s1 ? rd_s1 : '0;
	assign expected = old_f.last_seq + 32'd1;

	// Items that leave the table alone give an all-zero result but for the forward flag.
	always_comb begin
		fwd_res            = '0;
		fwd_res.forward_up = (head.kind == KIND_FWD);
	end

	always_comb begin
		new_f = old_f;
		if (cur_s1.seq_number == expected) begin
			new_f.last_seq = expected;
		end else if (cur_s1.seq_number > expected) begin
			new_f.loss     = old_f.loss + (cur_s1.seq_number - expected);
			new_f.last_seq = cur_s1.seq_number;
		end else begin
			new_f.loss = old_f.loss - 32'd1;
		end
		new_f.pkts  = old_f.pkts + 32'd1;
		new_f.bytes = old_f.bytes + 32'(cur_s1.pkt_size);
		// A stored maximum of zero marks the first sample of the flow.
		if (old_f.dmax == '0) begin
			new_f.dmax = cur_s1.delay;
			new_f.dmin = cur_s1.delay;
		end else begin
			if ($signed(old_f.dmax) < $signed(cur_s1.delay)) new_f.dmax = cur_s1.delay;
			if ($signed(cur_s1.delay) < $signed(old_f.dmin)) new_f.dmin = cur_s1.delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			res_q   <= '0;
			vld_s1  <= 1'b0;
			for (int i = 0; i < NUM_FLOWS; i++) vld_q[i] <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						if (is_stat) begin
							vld_s1  <= vld_q[head.flow];
							state_q <= ST_UPD;
						end else begin
							res_q  <= fwd_res;
							done_q <= 1'b1;
						end
					end
				end
				ST_UPD: begin
					res_q.forward_up      <= 1'b0;
					res_q.stats_updated   <= 1'b1;
					res_q.flow_pkt_count  <= new_f.pkts;
					res_q.flow_byte_count <= new_f.bytes;
					res_q.flow_loss_count <= new_f.loss;
					res_q.one_way_delay   <= cur_s1.delay;
					res_q.delay_min       <= new_f.dmin;
					res_q.delay_max       <= new_f.dmax;
					done_q                <= 1'b1;
					vld_q[cur_s1.flow]    <= 1'b1;
					state_q               <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_stat) begin
			rd_s1  <= mem[head.flow];
			cur_s1 <= head;
		end
		if (state_q == ST_UPD) mem[cur_s1.flow] <= new_f;
	end

endmodule

FILE: sv/per_flow_rx_sequence_and_delay_stats.sv
// Per-flow receive sequence and delay statistics, top level.
// A test packet's result is registered after the flow-table read and the update state,
// other items' results as they leave the queue; either may first wait in the two-entry queue.
// The back part takes no new item during a test packet's read-then-write pass over the
// single-port flow table. busy is high while the queue is full. Reset clears the queue,
// the state and the valid bits of the flow table at once, so every flow reads as zero after reset.
module per_flow_rx_sequence_and_delay_stats (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               packet_present,
	input  logic [3:0]         src_index,
	input  logic [3:0]         dst_index,
	input  logic signed [31:0] now_time,
	input  logic [15:0]        marker,
	input  logic [15:0]        pkt_size,
	input  logic [31:0]        seq_number,
	input  logic signed [31:0] send_time,
	output logic               done,
	output logic               forward_up,
	output logic               stats_updated,
	output logic [31:0]        flow_pkt_count,
	output logic [31:0]        flow_byte_count,
	output logic signed [31:0] flow_loss_count,
	output logic signed [31:0] one_way_delay,
	output logic signed [31:0] delay_min,
	output logic signed [31:0] delay_max
);
	import pfrs_pkg::*;

	item_t   push_item;
	item_t   head;
	logic    push;
	logic    pop;
	logic    q_empty;
	logic    q_full;
	result_t res;

	pfrs_front u_front (
		.start          (start),
		.q_full         (q_full),
		.busy           (busy),
		.push           (push),
		.packet_present (packet_present),
		.src_index      (src_index),
		.dst_index      (dst_index),
		.now_time       (now_time),
		.marker         (marker),
		.pkt_size       (pkt_size),
		.seq_number     (seq_number),
		.send_time      (send_time),
		.item           (push_item)
	);

	pfrs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	pfrs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.done   (done),
		.res    (res)
	);

	assign forward_up      = res.forward_up;
	assign stats_updated   = res.stats_updated;
	assign flow_pkt_count  = res.flow_pkt_count;
	assign flow_byte_count = res.flow_byte_count;
	assign flow_loss_count = res.flow_loss_count;
	assign one_way_delay   = res.one_way_delay;
	assign delay_min       = res.delay_min;
	assign delay_max       = res.delay_max;

endmodule

FILE: sv/pfrs_checker.sv
// Port-level checks for the per-flow statistics block, and the bind that attaches them.
// Depends on the top level's ports only.
module pfrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               forward_up,
	input logic               stats_updated,
	input logic [31:0]        flow_pkt_count,
	input logic [31:0]        flow_byte_count,
	input logic signed [31:0] flow_loss_count,
	input logic signed [31:0] one_way_delay,
	input logic signed [31:0] delay_min,
	input logic signed [31:0] delay_max
);

	// A transfer never claims both a forward and a statistics update.
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(forward_up && stats_updated))
		else $error("result both forwarded and counted");

	// Results without a statistics update carry zero in every counter field.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && !stats_updated |-> flow_pkt_count == 32'd0 && flow_byte_count == 32'd0
			&& flow_loss_count == 32'sd0 && one_way_delay == 32'sd0
			&& delay_min == 32'sd0 && delay_max == 32'sd0)
		else $error("non-statistics result has non-zero fields");

	// The packet's delay lies between the flow's minimum and maximum after the update.
	a_delay_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		done && stats_updated |-> delay_min <= one_way_delay && one_way_delay <= delay_max)
		else $error("delay outside the flow's min/max");

	// The queue only fills through an accepted transfer.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a preceding start");

endmodule

bind per_flow_rx_sequence_and_delay_stats pfrs_checker u_pfrs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.forward_up      (forward_up),
	.stats_updated   (stats_updated),
	.flow_pkt_count  (flow_pkt_count),
	.flow_byte_count (flow_byte_count),
	.flow_loss_count (flow_loss_count),
	.one_way_delay   (one_way_delay),
	.delay_min       (delay_min),
	.delay_max       (delay_max)
);

FILE: tb/per_flow_rx_sequence_and_delay_stats_test.sv
// Self-checking testbench for the per-flow receive sequence and delay statistics block.
// Predicts every result from its own copy of the flow tables and checks each strobed result.
// Depends on pfrs_pkg and per_flow_rx_sequence_and_delay_stats.
module per_flow_rx_sequence_and_delay_stats_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pfrs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_PKTS = 130;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic        present;
		logic [3:0]  src;
		logic [3:0]  dst;
		logic [31:0] now;
		logic [15:0] marker;
		logic [15:0] size;
		logic [31:0] seq;
		logic [31:0] sent;
	} rx_hdr_t;

	// A pending transfer, or a marker that holds the sender until every result is back.
	typedef struct packed {
		rx_hdr_t    hdr;
		logic       wait_idle;
		logic [6:0] idle_pct;
	} stim_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               packet_present = 1'b0;
	logic [3:0]         src_index = '0;
	logic [3:0]         dst_index = '0;
	logic signed [31:0] now_time = '0;
	logic [15:0]        marker = '0;
	logic [15:0]        pkt_size = '0;
	logic [31:0]        seq_number = '0;
	logic signed [31:0] send_time = '0;
	logic               done;
	logic               forward_up;
	logic               stats_updated;
	logic [31:0]        flow_pkt_count;
	logic [31:0]        flow_byte_count;
	logic signed [31:0] flow_loss_count;
	logic signed [31:0] one_way_delay;
	logic signed [31:0] delay_min;
	logic signed [31:0] delay_max;

	stim_t   pkt_q[$];
	result_t stats_due[$];
	int      errors = 0;
	int      cycles = 0;
	int      idle_now = 0;

	// Predictor state, one entry per flow.
	logic [31:0] last_seq  [NUM_FLOWS];
	logic [31:0] loss_cnt  [NUM_FLOWS];
	logic [31:0] pkt_cnt   [NUM_FLOWS];
	logic [31:0] byte_cnt  [NUM_FLOWS];
	logic [31:0] dly_max   [NUM_FLOWS];
	logic [31:0] dly_min   [NUM_FLOWS];
	// Highest sequence number sent per flow, used only to shape the stimulus.
	logic [31:0] sent_seq  [NUM_FLOWS];

	per_flow_rx_sequence_and_delay_stats dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.packet_present(packet_present), .src_index(src_index), .dst_index(dst_index),
		.now_time(now_time), .marker(marker), .pkt_size(pkt_size),
		.seq_number(seq_number), .send_time(send_time), .done(done),
		.forward_up(forward_up), .stats_updated(stats_updated),
		.flow_pkt_count(flow_pkt_count), .flow_byte_count(flow_byte_count),
		.flow_loss_count(flow_loss_count), .one_way_delay(one_way_delay),
		.delay_min(delay_min), .delay_max(delay_max)
	);

	always #4 clk = ~clk;

	function automatic result_t flow_stats_update(input rx_hdr_t h);
		result_t     r;
		logic [31:0] nxt;
		logic [31:0] dly;
		int          f;
		r = '0;
		if (!h.present)
			return r;
		if (h.marker != TEST_MARKER) begin
			r.forward_up = 1'b1;
			return r;
		end
		if (h.src >= NUM_SOURCES || h.dst >= NUM_DESTS)
			return r;
		f = h.src * NUM_DESTS + h.dst;
		nxt = last_seq[f] + 32'd1;
		if (h.seq == nxt) begin
			last_seq[f] = nxt;
		end else if (h.seq > nxt) begin
			loss_cnt[f] = loss_cnt[f] + (h.seq - nxt);
			last_seq[f] = h.seq;
		end else begin
			loss_cnt[f] = loss_cnt[f] - 32'd1;
		end
		pkt_cnt[f] = pkt_cnt[f] + 32'd1;
		byte_cnt[f] = byte_cnt[f] + {16'd0, h.size};
		dly = h.now - h.sent;
		// A stored maximum of zero is taken as "no sample yet", so it reseeds both ends.
		if (dly_max[f] == 32'd0) begin
			dly_max[f] = dly;
			dly_min[f] = dly;
		end else begin
			if ($signed(dly_max[f]) < $signed(dly))
				dly_max[f] = dly;
			if ($signed(dly) < $signed(dly_min[f]))
				dly_min[f] = dly;
		end
		r.stats_updated = 1'b1;
		r.flow_pkt_count = pkt_cnt[f];
		r.flow_byte_count = byte_cnt[f];
		r.flow_loss_count = loss_cnt[f];
		r.one_way_delay = dly;
		r.delay_min = dly_min[f];
		r.delay_max = dly_max[f];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MAX_REPORTS)
			$display("cycle %0d: %s got %h want %h", cycles, what, got, want);
		errors++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic add_pkt(input logic present, input logic [3:0] src, input logic [3:0] dst,
			input logic [31:0] now, input logic [15:0] mark, input logic [15:0] size,
			input logic [31:0] seq, input logic [31:0] sent);
		stim_t s;
		int    f;
		s.hdr = '{present, src, dst, now, mark, size, seq, sent};
		s.wait_idle = 1'b0;
		s.idle_pct = idle_now[6:0];
		pkt_q.push_back(s);
		f = src * NUM_DESTS + dst;
		if (present && mark == TEST_MARKER && seq >= sent_seq[f] + 32'd1)
			sent_seq[f] = seq;
	endtask

	task automatic add_drain();
		stim_t s;
		s = '0;
		s.wait_idle = 1'b1;
		pkt_q.push_back(s);
	endtask

	task automatic add_random_items(input int n_test);
		int          made;
		int          kind;
		int          pick;
		int          f;
		logic [3:0]  src;
		logic [3:0]  dst;
		logic [31:0] nxt;
		logic [31:0] seq;
		logic [31:0] sent;
		logic [31:0] now;
		logic [15:0] mark;
		made = 0;
		while (made < n_test) begin
			kind = $urandom_range(99, 0);
			sent = $urandom;
			now = $urandom;
			if (kind >= 75) begin
				// Absent packets and ordinary traffic for the upper layer.
				mark = (kind < 88) ? 16'($urandom_range(16'hFFFE, 0)) : 16'($urandom);
				add_pkt(kind < 88, 4'($urandom), 4'($urandom), now, mark,
					16'($urandom), $urandom, sent);
			end else begin
				// Most test packets go to a few busy flows so that their history runs deep.
				if ($urandom_range(99, 0) < 70) begin
					pick = $urandom_range(3, 0);
					src = 4'(pick * 5);
					dst = 4'(pick * 4 + 1);
				end else begin
					src = 4'($urandom);
					dst = 4'($urandom);
				end
				f = src * NUM_DESTS + dst;
				nxt = sent_seq[f] + 32'd1;
				pick = $urandom_range(99, 0);
				if (pick < 65)
					seq = nxt;
				else if (pick < 80)
					seq = nxt + $urandom_range(20, 1);
				else if (pick < 92)
					seq = nxt - $urandom_range(10, 1);
				else
					seq = $urandom;
				pick = $urandom_range(99, 0);
				if (pick < 80)
					now = sent + $urandom_range(2000, 0);
				else if (pick < 88)
					now = sent - $urandom_range(500, 1);
				else if (pick < 91)
					now = sent;
				add_pkt(1'b1, src, dst, now, TEST_MARKER, 16'($urandom), seq, sent);
				made++;
			end
		end
	endtask

	// Driver: a transfer takes place at an edge where start is high and busy is low.
	always @(posedge clk) begin : drive_proc
		logic launch;
		if (arst_n) begin
			launch = !start;
			if (start && !busy) begin
				stats_due.push_back(flow_stats_update(pkt_q[0].hdr));
				void'(pkt_q.pop_front());
				launch = 1'b1;
			end
			if (launch) begin
				if (pkt_q.size() == 0) begin
					start <= 1'b0;
				end else if (pkt_q[0].wait_idle) begin
					start <= 1'b0;
					if (stats_due.size() == 0)
						void'(pkt_q.pop_front());
				end else if ($urandom_range(99, 0) < pkt_q[0].idle_pct) begin
					start <= 1'b0;
				end else begin
					start <= 1'b1;
					packet_present <= pkt_q[0].hdr.present;
					src_index <= pkt_q[0].hdr.src;
					dst_index <= pkt_q[0].hdr.dst;
					now_time <= pkt_q[0].hdr.now;
					marker <= pkt_q[0].hdr.marker;
					pkt_size <= pkt_q[0].hdr.size;
					seq_number <= pkt_q[0].hdr.seq;
					send_time <= pkt_q[0].hdr.sent;
				end
			end
		end
	end

	// Monitor: a result is valid only in the cycle that done marks.
	always @(posedge clk) begin : check_proc
		result_t want;
		if (arst_n && done) begin
			if (stats_due.size() == 0) begin
				report_mismatch("result with none outstanding", 32'd0, 32'd0);
			end else begin
				want = stats_due.pop_front();
				check_field("forward_up", {31'd0, forward_up}, {31'd0, want.forward_up});
				check_field("stats_updated", {31'd0, stats_updated},
					{31'd0, want.stats_updated});
				check_field("flow_pkt_count", flow_pkt_count, want.flow_pkt_count);
				check_field("flow_byte_count", flow_byte_count, want.flow_byte_count);
				check_field("flow_loss_count", flow_loss_count, want.flow_loss_count);
				check_field("one_way_delay", one_way_delay, want.one_way_delay);
				check_field("delay_min", delay_min, want.delay_min);
				check_field("delay_max", delay_max, want.delay_max);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("per_flow_rx_sequence_and_delay_stats test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_FLOWS; i++) begin
			last_seq[i] = '0;
			loss_cnt[i] = '0;
			pkt_cnt[i] = '0;
			byte_cnt[i] = '0;
			dly_max[i] = '0;
			dly_min[i] = '0;
			sent_seq[i] = '0;
		end

		// Directed part: absent and forwarded packets, then sequence and delay corner cases.
		add_pkt(1'b0, 4'd15, 4'd15, $urandom, TEST_MARKER, 16'hFFFF, $urandom, $urandom);
		add_pkt(1'b1, 4'd2, 4'd3, $urandom, 16'h0000, 16'd64, 32'd1, $urandom);
		add_pkt(1'b1, 4'd0, 4'd0, $urandom, 16'hFFFE, 16'd0, 32'd1, $urandom);
		add_pkt(1'b1, 4'd15, 4'd0, $urandom, 16'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, $urandom);
		// Flow (0,0): in order, a gap, a late packet, and the sequence number wrapping.
		add_pkt(1'b1, 4'd0, 4'd0, 32'd100, TEST_MARKER, 16'd0, 32'd1, 32'd90);
		add_pkt(1'b1, 4'd0, 4'd0, 32'd200, TEST_MARKER, 16'd1500, 32'd2, 32'd180);
		add_pkt(1'b1, 4'd0, 4'd0, 32'd300, TEST_MARKER, 16'd40, 32'd10, 32'd295);
		add_pkt(1'b1, 4'd0, 4'd0, 32'd400, TEST_MARKER, 16'd40, 32'd5, 32'd390);
		add_pkt(1'b1, 4'd0, 4'd0, 32'd500, TEST_MARKER, 16'd40, 32'hFFFF_FFFF, 32'd490);
		add_pkt(1'b1, 4'd0, 4'd0, 32'd600, TEST_MARKER, 16'd40, 32'd0, 32'd590);
		// Flow (15,15): a late first packet and delays at the signed extremes.
		add_pkt(1'b1, 4'd15, 4'd15, 32'h7FFF_FFFF, TEST_MARKER, 16'hFFFF, 32'd0,
			32'h8000_0000);
		add_pkt(1'b1, 4'd15, 4'd15, 32'h8000_0000, TEST_MARKER, 16'hFFFF, 32'd1,
			32'h7FFF_FFFF);
		add_pkt(1'b1, 4'd15, 4'd15, 32'h8000_0000, TEST_MARKER, 16'hFFFF, 32'd2, 32'd0);
		add_pkt(1'b1, 4'd15, 4'd15, 32'h7FFF_FFFF, TEST_MARKER, 16'hFFFF, 32'd3, 32'd0);
		// Flow (3,5): a zero first delay leaves the maximum at zero, so the next one reseeds.
		add_pkt(1'b1, 4'd3, 4'd5, 32'd1000, TEST_MARKER, 16'd100, 32'd1, 32'd1000);
		add_pkt(1'b1, 4'd3, 4'd5, 32'd1007, TEST_MARKER, 16'd100, 32'd2, 32'd1000);
		add_pkt(1'b1, 4'd3, 4'd5, 32'd995, TEST_MARKER, 16'd100, 32'd3, 32'd1000);
		add_pkt(1'b0, 4'd0, 4'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0);
		add_drain();

		// Random part in phases of differing sender idling, with a full drain between them.
		idle_now = 0;
		add_random_items(PHASE_PKTS / 2);
		add_drain();
		add_random_items(PHASE_PKTS - PHASE_PKTS / 2);
		add_drain();
		idle_now = 56;
		add_random_items(PHASE_PKTS);
		add_drain();
		idle_now = 0;
		add_random_items(PHASE_PKTS);
		add_drain();
		idle_now = 27;
		add_random_items(PHASE_PKTS);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pkt_q.size() != 0 || stats_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("per_flow_rx_sequence_and_delay_stats test passed");
		else
			$display("per_flow_rx_sequence_and_delay_stats test failed");
		$finish;
	end

endmodule
